[design/rrlm_pkg.sv]
// Package for the request/response latency matcher.
// Outcome codes, opcode values and the controller/datapath command and status structs.
// No dependencies.
package rrlm_pkg;

    localparam logic [2:0] OUT_STORED   = 3'd0;
    localparam logic [2:0] OUT_MATCHED  = 3'd1;
    localparam logic [2:0] OUT_DUP_RECV = 3'd2;
    localparam logic [2:0] OUT_SEND_UPD = 3'd3;
    localparam logic [2:0] OUT_DROPPED  = 3'd4;

    localparam logic OP_RECV = 1'b0;
    localparam logic OP_SEND = 1'b1;

    typedef struct packed {
        logic capture;   // latch the input beat, start the search
        logic scan;      // advance the search by one slot
        logic commit;    // apply the update and load the result
    } t_cmd;

    typedef struct packed {
        logic scan_done; // search has covered every slot
    } t_status;

endpackage

[design/rrlm_ctrl.sv]
// Controller for the latency matcher: sequences capture, slot scan and commit.
// Depends on rrlm_pkg.
module rrlm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  rrlm_pkg::t_status i_status,
    output rrlm_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || !i_stall;
    // hold the input closed during reset and while an event is in work
    assign o_stall  = !i_rst_n || (r_state != S_IDLE);
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTH
    a_commit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> out_free) else $error("commit while output held");
    a_valid_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_valid) else $error("no result after commit");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_stall) else $error("input open during search");
`endif

endmodule

[design/rrlm_dp.sv]
// Datapath for the latency matcher: slot table, sequential id search, counters.
// Depends on rrlm_pkg.
module rrlm_dp #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rrlm_pkg::t_cmd    i_cmd,
    output rrlm_pkg::t_status o_status,
    input  logic             i_op,
    input  logic [63:0]      i_msg_id,
    input  logic [63:0]      i_event_time,
    output logic [2:0]       o_outcome,
    output logic [63:0]      o_latency,
    output logic [63:0]      o_latency_total,
    output logic [63:0]      o_match_total,
    output logic [63:0]      o_send_total,
    output logic [63:0]      o_receive_total
);

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);

    logic [TABLE_SLOTS-1:0] r_valid;
    logic [63:0] mem_key  [TABLE_SLOTS];
    logic [63:0] mem_rtime[TABLE_SLOTS];
    logic        mem_seen [TABLE_SLOTS];

    logic        r_op;
    logic [63:0] r_id, r_time;
    logic [CW-1:0] r_idx;
    logic        r_hit, r_free_f;
    logic [IW-1:0] r_hit_idx, r_free_idx;
    logic [63:0] r_rd_key, r_rd_rtime;
    logic        r_rd_seen, r_rd_ok;
    logic [IW-1:0] r_rd_idx;
    logic [63:0] r_hit_rtime;
    logic        r_hit_seen;
    logic [63:0] r_sum, r_match, r_send, r_recv;
    logic [2:0]  r_outcome;
    logic [63:0] r_lat;

    logic [IW-1:0] rd_addr;
    logic          is_hit;
    logic [63:0]   lat;

    assign rd_addr = r_idx[IW-1:0];
    assign o_status.scan_done = !r_rd_ok && (r_idx == CW'(TABLE_SLOTS));
    assign is_hit  = r_rd_ok && r_valid[r_rd_idx] && (r_rd_key == r_id) && !r_hit;
    assign lat     = r_time - r_hit_rtime;

    // memory reads, one slot per cycle, registered
    always_ff @(posedge i_clk) begin
        r_rd_key   <= mem_key[rd_addr];
        r_rd_rtime <= mem_rtime[rd_addr];
        r_rd_seen  <= mem_seen[rd_addr];
        r_rd_idx   <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !r_hit && r_free_f) begin
            mem_key[r_free_idx]   <= r_id;
            mem_rtime[r_free_idx] <= r_time;
            mem_seen[r_free_idx]  <= (r_op == rrlm_pkg::OP_RECV);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_id   <= i_msg_id;
            r_time <= i_event_time;
        end
        if (is_hit) begin
            r_hit_idx   <= r_rd_idx;
            r_hit_rtime <= r_rd_rtime;
            r_hit_seen  <= r_rd_seen;
        end
        if (i_cmd.scan && r_rd_ok && !r_valid[r_rd_idx] && !r_free_f)
            r_free_idx <= r_rd_idx;
        if (i_cmd.commit) begin
            r_lat <= '0;
            if (r_hit) begin
                if (r_op == rrlm_pkg::OP_RECV) r_outcome <= rrlm_pkg::OUT_DUP_RECV;
                else if (r_hit_seen) begin
                    r_outcome <= rrlm_pkg::OUT_MATCHED;
                    r_lat     <= lat;
                end else r_outcome <= rrlm_pkg::OUT_SEND_UPD;
            end else if (r_free_f) r_outcome <= rrlm_pkg::OUT_STORED;
            else r_outcome <= rrlm_pkg::OUT_DROPPED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_idx    <= '0;
            r_rd_ok  <= 1'b0;
            r_hit    <= 1'b0;
            r_free_f <= 1'b0;
            r_sum    <= '0;
            r_match  <= '0;
            r_send   <= '0;
            r_recv   <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_idx    <= '0;
                r_rd_ok  <= 1'b0;
                r_hit    <= 1'b0;
                r_free_f <= 1'b0;
            end else if (i_cmd.scan) begin
                // issue the next read while checking the one that returned
                r_rd_ok <= (r_idx != CW'(TABLE_SLOTS));
                if (r_idx != CW'(TABLE_SLOTS)) r_idx <= r_idx + 1'b1;
                if (is_hit) r_hit <= 1'b1;
                if (r_rd_ok && !r_valid[r_rd_idx]) r_free_f <= 1'b1;
            end
            if (i_cmd.commit) begin
                if (r_hit) begin
                    if (r_op == rrlm_pkg::OP_RECV) r_recv <= r_recv + 64'd1;
                    else begin
                        r_send <= r_send + 64'd1;
                        if (r_hit_seen) begin
                            r_sum   <= r_sum + lat;
                            r_match <= r_match + 64'd1;
                            r_valid[r_hit_idx] <= 1'b0;
                        end
                    end
                end else if (r_free_f) begin
                    r_valid[r_free_idx] <= 1'b1;
                    if (r_op == rrlm_pkg::OP_RECV) r_recv <= r_recv + 64'd1;
                    else r_send <= r_send + 64'd1;
                end
            end
        end
    end

    assign o_outcome       = r_outcome;
    assign o_latency       = r_lat;
    assign o_latency_total = r_sum;
    assign o_match_total   = r_match;
    assign o_send_total    = r_send;
    assign o_receive_total = r_recv;

`ifndef SYNTH
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= CW'(TABLE_SLOTS)) else $error("scan index out of range");
    a_match_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_hit && r_op == rrlm_pkg::OP_SEND && r_hit_seen)
        |=> r_match == $past(r_match) + 64'd1) else $error("match count slip");
    a_drop_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !r_hit && !r_free_f) |=> $stable(r_valid))
        else $error("dropped beat changed table");
`endif

endmodule

[design/request_response_latency_matcher.sv]
// Top level of the request/response latency matcher.
// Instantiates rrlm_ctrl and rrlm_dp; uses rrlm_pkg.
//
//  channel | direction | handshake           | payload
//  event   | in        | i_valid / o_stall   | i_op, i_msg_id, i_event_time
//  result  | out       | o_valid / i_stall   | o_outcome, o_latency, totals
//
// The result becomes valid after its event is accepted and searched: the
// id search reads one slot of the table memory per cycle through its single
// read port, drains the last read, then commits.
// A new event is accepted only after the previous one has committed.
// Reset is synchronous, active low; it clears all slot valid bits and counters
// and holds o_stall high.
// A held result stalls only the commit; the search still runs meanwhile.
module request_response_latency_matcher #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [63:0] i_msg_id,
    input  logic [63:0] i_event_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_outcome,
    output logic [63:0] o_latency,
    output logic [63:0] o_latency_total,
    output logic [63:0] o_match_total,
    output logic [63:0] o_send_total,
    output logic [63:0] o_receive_total
);

    rrlm_pkg::t_cmd    cmd;
    rrlm_pkg::t_status status;

    rrlm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall),
        .i_status(status), .o_cmd(cmd)
    );

    rrlm_dp #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_status(status),
        .i_op(i_op), .i_msg_id(i_msg_id), .i_event_time(i_event_time),
        .o_outcome(o_outcome), .o_latency(o_latency),
        .o_latency_total(o_latency_total), .o_match_total(o_match_total),
        .o_send_total(o_send_total), .o_receive_total(o_receive_total)
    );

endmodule

[sim/tb.sv]
// Testbench for request_response_latency_matcher: random bursts of receive/send events.
// Predicts each result with a local pending-id table and checks every output beat.
// Depends on rrlm_pkg and the design top level.
module tb;

    localparam int SLOTS = 64;
    localparam int LIMIT = 2000000;

    typedef struct {
        logic        op;
        logic [63:0] msg_id;
        logic [63:0] event_time;
    } t_event;

    typedef struct {
        logic [2:0]  outcome;
        logic [63:0] latency;
        logic [63:0] latency_total;
        logic [63:0] match_total;
        logic [63:0] send_total;
        logic [63:0] receive_total;
    } t_result;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        i_op = 0;
    logic [63:0] i_msg_id = 0;
    logic [63:0] i_event_time = 0;
    logic        i_stall = 0;
    logic        o_stall, o_valid;
    logic [2:0]  o_outcome;
    logic [63:0] o_latency, o_latency_total, o_match_total, o_send_total, o_receive_total;

    request_response_latency_matcher #(.TABLE_SLOTS(SLOTS)) dut (.*);

    t_event  pending_events[$];
    t_result expected_results[$];
    int      errors = 0;
    int      cycle = 0;
    bit      stim_done = 0;

    // predictor state
    bit          p_valid[SLOTS];
    logic [63:0] p_key[SLOTS];
    logic [63:0] p_rtime[SLOTS];
    bit          p_rseen[SLOTS];
    logic [63:0] p_sum, p_matches, p_sends, p_recvs;

    function automatic t_result predict_turnaround(t_event ev);
        t_result r;
        int hit, fr;
        hit = -1;
        fr = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && p_valid[i] && p_key[i] == ev.msg_id) hit = i;
            if (fr < 0 && !p_valid[i]) fr = i;
        end
        r.latency = 0;
        if (ev.op == rrlm_pkg::OP_RECV) begin
            if (hit >= 0) begin
                p_recvs++;
                r.outcome = rrlm_pkg::OUT_DUP_RECV;
            end else if (fr < 0) begin
                r.outcome = rrlm_pkg::OUT_DROPPED;
            end else begin
                p_valid[fr] = 1; p_key[fr] = ev.msg_id;
                p_rtime[fr] = ev.event_time; p_rseen[fr] = 1;
                p_recvs++;
                r.outcome = rrlm_pkg::OUT_STORED;
            end
        end else begin
            if (hit >= 0) begin
                if (p_rseen[hit]) begin
                    r.latency = ev.event_time - p_rtime[hit];
                    p_sum += r.latency;
                    p_matches++;
                    p_valid[hit] = 0;
                    r.outcome = rrlm_pkg::OUT_MATCHED;
                end else begin
                    r.outcome = rrlm_pkg::OUT_SEND_UPD;
                end
                p_sends++;
            end else if (fr < 0) begin
                r.outcome = rrlm_pkg::OUT_DROPPED;
            end else begin
                p_valid[fr] = 1; p_key[fr] = ev.msg_id;
                p_rtime[fr] = 0; p_rseen[fr] = 0;
                p_sends++;
                r.outcome = rrlm_pkg::OUT_STORED;
            end
        end
        r.latency_total = p_sum;
        r.match_total = p_matches;
        r.send_total = p_sends;
        r.receive_total = p_recvs;
        return r;
    endfunction

    function automatic t_event mk(logic op, logic [63:0] id, logic [63:0] t);
        t_event e;
        e.op = op; e.msg_id = id; e.event_time = t;
        return e;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        logic [63:0] ids[$];
        logic [63:0] id, t;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        // directed: extremes, duplicate receive, send-only entry, wrap
        pending_events.push_back(mk(rrlm_pkg::OP_RECV, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF));
        pending_events.push_back(mk(rrlm_pkg::OP_RECV, 64'h0, 64'h5));
        pending_events.push_back(mk(rrlm_pkg::OP_SEND, 64'h0, 64'h4));
        pending_events.push_back(mk(rrlm_pkg::OP_SEND, '1, 64'h10));
        pending_events.push_back(mk(rrlm_pkg::OP_RECV, '1, 64'h20));
        pending_events.push_back(mk(rrlm_pkg::OP_SEND, '1, '1));
        pending_events.push_back(mk(rrlm_pkg::OP_RECV, 64'h1234, 64'h0));
        pending_events.push_back(mk(rrlm_pkg::OP_SEND, 64'h1234, '1));
        // fill the table to force drops, then drain
        for (int i = 0; i < SLOTS + 2; i++)
            pending_events.push_back(mk(rrlm_pkg::OP_RECV, 64'h100 + 64'(i), 64'(i)));
        pending_events.push_back(mk(rrlm_pkg::OP_SEND, 64'h100 + 64'(3 * SLOTS), 64'd1));
        for (int i = 0; i < SLOTS; i++)
            pending_events.push_back(mk(rrlm_pkg::OP_SEND, 64'h100 + 64'(i), rand64()));
        // random: mostly paired traffic from a small id pool, some noise
        for (int n = 0; n < 2000; n++) begin
            t = rand64();
            case ($urandom_range(0, 9))
                0: id = rand64();
                1: id = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, $urandom()};
                default: id = 64'($urandom_range(0, 80));
            endcase
            if ($urandom_range(0, 3) == 0 && ids.size() > 0) begin
                id = ids[$urandom_range(0, ids.size() - 1)];
            end
            pending_events.push_back(mk(1'($urandom_range(0, 1)), id, t));
            if (ids.size() < 40) ids.push_back(id);
        end
        stim_done = 1;
    end

    // driver: bursts of random length with random gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        t_event ev;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                ev = mk(i_op, i_msg_id, i_event_time);
                expected_results.push_back(predict_turnaround(ev));
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 0;
                end else if (pending_events.size() > 0) begin
                    ev = pending_events.pop_front();
                    i_valid <= 1;
                    i_op <= ev.op;
                    i_msg_id <= ev.msg_id;
                    i_event_time <= ev.event_time;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 150);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge i_clk) begin
        t_result e;
        cycle <= cycle + 1;
        if (i_rst_n) begin
            i_stall <= (cycle[9:8] == 2'd1) ? 1'b0 : ($urandom_range(0, 3) == 0);
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_outcome !== e.outcome) begin
                        $error("outcome exp %0d got %0d", e.outcome, o_outcome); errors++;
                    end
                    if (o_latency !== e.latency) begin
                        $error("latency exp %0h got %0h", e.latency, o_latency); errors++;
                    end
                    if (o_latency_total !== e.latency_total) begin
                        $error("latency_total exp %0h got %0h", e.latency_total,
                               o_latency_total);
                        errors++;
                    end
                    if (o_match_total !== e.match_total) begin
                        $error("match_total exp %0h got %0h", e.match_total, o_match_total);
                        errors++;
                    end
                    if (o_send_total !== e.send_total) begin
                        $error("send_total exp %0h got %0h", e.send_total, o_send_total);
                        errors++;
                    end
                    if (o_receive_total !== e.receive_total) begin
                        $error("receive_total exp %0h got %0h", e.receive_total,
                               o_receive_total);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        p_sum = 0; p_matches = 0; p_sends = 0; p_recvs = 0;
        for (int i = 0; i < SLOTS; i++) p_valid[i] = 0;
        wait (stim_done);
        while (cycle < LIMIT && (pending_events.size() > 0 || i_valid ||
               expected_results.size() > 0))
            @(posedge i_clk);
        repeat (2 * SLOTS + 20) @(posedge i_clk);
        if (cycle >= LIMIT) begin
            $display("TB_ERROR");
        end else if (errors == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
